// File: rtl/core/apc_pkg.sv
// types, constants and codes shared by the signal phase controller
`timescale 1ns / 1ps

package apc_pkg;

    // transaction kinds
    localparam logic [1:0] KIND_GAP  = 2'd0;
    localparam logic [1:0] KIND_EVAL = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DET_GAP     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_ENABLE  = 8'd3;

    // configuration reset values
    localparam logic [4:0]  RST_PHASE_COUNT = 5'd4;
    localparam logic [15:0] RST_MAX_GAP     = 16'd3100;
    localparam logic [15:0] RST_DET_GAP     = 16'd3000;
    localparam logic        RST_GAP_ENABLE  = 1'b1;

    // whole-second rounding
    localparam logic [24:0] MS_PER_SEC = 25'd1000;
    localparam logic [3:0]  DIV_TOP    = 4'd1;

    // ceil(2^35 / 1000), exact quotient for operands below 2^25
    localparam logic [25:0] RECIP_1000  = 26'd34359739;
    localparam int          RECIP_SHIFT = 35;

    // width of one phase table entry
    localparam int ENTRY_W = 24 + 24 + 1 + 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [3:0]  detector_index;
        logic [15:0] gap_ms;
        logic [3:0]  phase_slot;
        logic [23:0] min_time_ms;
        logic [23:0] max_time_ms;
        logic        green_flag;
        logic [15:0] green_detectors;
    } in_item_t;

    typedef struct packed {
        logic [23:0] next_delay_ms;
        logic [3:0]  active_phase;
        logic        switched;
    } out_item_t;

    typedef struct packed {
        logic [23:0] min_time;
        logic [23:0] max_time;
        logic        green;
        logic [15:0] mask;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_PREP,
        S_PREP2,
        S_DIV,
        S_ROUND,
        S_ADV,
        S_ADV_RD,
        S_ADV_CAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic load;
        logic scan;
        logic prep;
        logic prep2;
        logic div;
        logic round;
        logic adv;
        logic adv_cap;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_eval;
        logic scan_last;
        logic found;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/core/apc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module apc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/apc_datapath.sv
// datapath: configuration, detector gaps, phase table, scan, rounding, result register
`timescale 1ns / 1ps

module apc_datapath #(
    parameter int NUM_PHASES    = 16,
    parameter int NUM_DETECTORS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  apc_pkg::cmd_t                    cmd,
    output apc_pkg::status_t                 status,
    input  logic                             s_valid,
    input  apc_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output apc_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    input  logic [apc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PAW    = $clog2(NUM_PHASES);
    localparam int DW     = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int NDS    = (NUM_DETECTORS < 16) ? NUM_DETECTORS : 16;
    localparam int SCW    = (NDS > 1) ? $clog2(NDS) : 1;
    localparam int LIM    = (NUM_PHASES < 16) ? NUM_PHASES : 16;

    // configuration registers
    logic [4:0]  phase_count_reg;
    logic [15:0] max_gap_reg;
    logic [15:0] det_gap_reg;
    logic        gap_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg <= apc_pkg::RST_PHASE_COUNT;
            max_gap_reg     <= apc_pkg::RST_MAX_GAP;
            det_gap_reg     <= apc_pkg::RST_DET_GAP;
            gap_en_reg      <= apc_pkg::RST_GAP_ENABLE;
        end else if (cfg_valid) begin
            case (cfg_index)
                apc_pkg::CFG_PHASE_COUNT: phase_count_reg <= cfg_data[4:0];
                apc_pkg::CFG_MAX_GAP:     max_gap_reg     <= cfg_data;
                apc_pkg::CFG_DET_GAP:     det_gap_reg     <= cfg_data;
                apc_pkg::CFG_GAP_ENABLE:  gap_en_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic accept;
    assign accept = s_valid && cmd.take;

    // captured transaction
    apc_pkg::in_item_t item_reg;
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    // detector gap store and scan counter
    logic [15:0]    gap_reg [NUM_DETECTORS];
    logic [SCW-1:0] scan_reg;
    logic           gap_we;
    assign gap_we = accept && (s_data.kind == apc_pkg::KIND_GAP)
                    && (32'(s_data.detector_index) < NUM_DETECTORS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DETECTORS; i++) begin
                gap_reg[i] <= 16'hFFFF;
            end
        end else if (gap_we) begin
            gap_reg[DW'(s_data.detector_index)] <= s_data.gap_ms;
        end
    end

    // phase table
    apc_pkg::entry_t wr_entry;
    apc_pkg::entry_t rd_entry;
    logic [apc_pkg::ENTRY_W-1:0] rd_bits;
    logic ph_we;
    logic [3:0] cur_phase_reg;

    assign wr_entry = '{min_time: s_data.min_time_ms, max_time: s_data.max_time_ms,
                        green: s_data.green_flag, mask: s_data.green_detectors};
    assign ph_we = accept && (s_data.kind == apc_pkg::KIND_LOAD)
                   && (32'(s_data.phase_slot) < NUM_PHASES);
    assign rd_entry = apc_pkg::entry_t'(rd_bits);

    apc_ram #(
        .WIDTH (apc_pkg::ENTRY_W),
        .DEPTH (NUM_PHASES)
    ) u_phase_ram (
        .aclk  (aclk),
        .we    (ph_we),
        .waddr (PAW'(s_data.phase_slot)),
        .wdata (wr_entry),
        .raddr (PAW'(cur_phase_reg)),
        .rdata (rd_bits)
    );

    // phase entry, elapsed time and eligibility
    apc_pkg::entry_t ent_reg;
    logic [23:0] act_reg;
    logic        elig_reg;
    logic [31:0] act_full;
    logic [31:0] start_reg;
    assign act_full = item_reg.now_ms - start_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ent_reg  <= rd_entry;
            act_reg  <= act_full[23:0];
            elig_reg <= rd_entry.green && gap_en_reg
                        && (act_full < {8'd0, rd_entry.max_time});
        end
    end

    // masked minimum gap scan
    logic [15:0] best_reg;
    logic        found_reg;
    logic [15:0] scan_gap;
    logic        scan_hit;
    assign scan_gap = gap_reg[DW'(scan_reg)];
    assign scan_hit = elig_reg && ent_reg.mask[4'(scan_reg)] && (scan_gap < max_gap_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end else if (cmd.scan) begin
            scan_reg <= scan_reg + SCW'(1);
            if (scan_hit) begin
                found_reg <= 1'b1;
                if (!found_reg || scan_gap < best_reg) begin
                    best_reg <= scan_gap;
                end
            end
        end
    end

    // extension before rounding: max of remaining min, gap lead and one
    logic signed [25:0] d_min;
    logic signed [25:0] d_gap;
    logic signed [25:0] d_max;
    logic [24:0] d_reg;
    assign d_min = $signed({2'b00, ent_reg.min_time}) - $signed({2'b00, act_reg});
    assign d_gap = $signed({10'd0, det_gap_reg}) - $signed({10'd0, best_reg});
    assign d_max = (d_gap > d_min) ? d_gap : d_min;

    // remainders by 1000 through a reciprocal multiply, two steps
    logic [24:0] tot_reg;
    logic [15:0] qd_reg;
    logic [15:0] qt_reg;
    logic [24:0] rd_reg;
    logic [24:0] rt_reg;
    logic [3:0]  k_reg;
    logic [50:0] prod_d;
    logic [50:0] prod_t;
    assign prod_d = 51'(d_reg) * 51'(apc_pkg::RECIP_1000);
    assign prod_t = 51'(tot_reg) * 51'(apc_pkg::RECIP_1000);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            d_reg <= (d_max < 26'sd1) ? 25'd1 : d_max[24:0];
        end
        if (cmd.prep2) begin
            tot_reg <= d_reg + {1'b0, act_reg};
            qd_reg  <= prod_d[apc_pkg::RECIP_SHIFT +: 16];
            k_reg   <= apc_pkg::DIV_TOP;
        end else if (cmd.div) begin
            qt_reg <= prod_t[apc_pkg::RECIP_SHIFT +: 16];
            rd_reg <= d_reg - 25'(qd_reg) * apc_pkg::MS_PER_SEC;
            rt_reg <= tot_reg - 25'(qt_reg) * apc_pkg::MS_PER_SEC;
            k_reg  <= k_reg - 4'd1;
        end
    end

    // round up to the whole second and cap at max
    logic [25:0] d_up;
    logic [23:0] cap;
    assign d_up = (rd_reg != 25'd0)
                  ? ({1'b0, d_reg} + {1'b0, apc_pkg::MS_PER_SEC} - {1'b0, rt_reg})
                  : {1'b0, d_reg};
    assign cap = ent_reg.max_time - act_reg;

    // next phase in the cycle
    logic [4:0] cyc_len;
    logic [4:0] nxt;
    always_comb begin
        cyc_len = phase_count_reg;
        if (cyc_len < 5'd1) cyc_len = 5'd1;
        if (32'(cyc_len) > LIM) cyc_len = 5'(LIM);
        nxt = {1'b0, cur_phase_reg} + 5'd1;
        if (nxt >= cyc_len) nxt = 5'd0;
    end

    // phase state and pending result
    apc_pkg::out_item_t res_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_phase_reg <= '0;
            start_reg     <= '0;
        end else if (cmd.adv) begin
            cur_phase_reg <= nxt[3:0];
            start_reg     <= item_reg.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            res_reg.next_delay_ms <= (d_up > {2'b00, cap}) ? cap : d_up[23:0];
            res_reg.active_phase  <= cur_phase_reg;
            res_reg.switched      <= 1'b0;
        end else if (cmd.adv_cap) begin
            res_reg.next_delay_ms <= rd_entry.min_time;
            res_reg.active_phase  <= cur_phase_reg;
            res_reg.switched      <= 1'b1;
        end
    end

    // output register
    logic               m_valid_reg;
    apc_pkg::out_item_t m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.in_eval   = (s_data.kind == apc_pkg::KIND_EVAL);
    assign status.scan_last = (scan_reg == SCW'(NDS - 1));
    assign status.found     = found_reg;
    assign status.div_last  = (k_reg == 4'd0);
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

// File: rtl/core/apc_ctrl.sv
// controller state machine sequencing one evaluate transaction
`timescale 1ns / 1ps

module apc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  apc_pkg::status_t  status,
    output apc_pkg::cmd_t     cmd
);

    apc_pkg::state_t state_reg;
    apc_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            apc_pkg::S_IDLE: begin
                cmd.take = 1'b1;
                if (s_valid && status.in_eval) state_next = apc_pkg::S_LOAD;
            end
            apc_pkg::S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = apc_pkg::S_SCAN;
            end
            apc_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) state_next = apc_pkg::S_PICK;
            end
            apc_pkg::S_PICK: begin
                state_next = status.found ? apc_pkg::S_PREP : apc_pkg::S_ADV;
            end
            apc_pkg::S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = apc_pkg::S_PREP2;
            end
            apc_pkg::S_PREP2: begin
                cmd.prep2  = 1'b1;
                state_next = apc_pkg::S_DIV;
            end
            apc_pkg::S_DIV: begin
                cmd.div = 1'b1;
                if (status.div_last) state_next = apc_pkg::S_ROUND;
            end
            apc_pkg::S_ROUND: begin
                cmd.round  = 1'b1;
                state_next = apc_pkg::S_DONE;
            end
            apc_pkg::S_ADV: begin
                cmd.adv    = 1'b1;
                state_next = apc_pkg::S_ADV_RD;
            end
            apc_pkg::S_ADV_RD: begin
                state_next = apc_pkg::S_ADV_CAP;
            end
            apc_pkg::S_ADV_CAP: begin
                cmd.adv_cap = 1'b1;
                state_next  = apc_pkg::S_DONE;
            end
            apc_pkg::S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = apc_pkg::S_IDLE;
                end
            end
            default: state_next = apc_pkg::S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/actuated_signal_phase_controller.sv
// top level of the gap-out actuated signal phase controller
//
//   channel | ports                           | carries
//   --------+---------------------------------+----------------------------------
//   input   | s_valid s_ready s_data          | gap report, evaluate, phase load
//   result  | m_valid m_ready m_data          | delay, active phase, switched flag
//   config  | cfg_valid cfg_ready cfg_index/data | register writes, always ready
//
// gap reports and phase loads are taken back to back while no evaluate is in progress.
// an evaluate scans its phase's detectors, then switches to the next phase or extends;
// an extension takes a two-step reciprocal remainder by 1000 before rounding.
// one evaluate is worked at a time; its result waits in the output register.
// reset is synchronous; detector gaps reset to all ones, the phase table is not cleared.
`timescale 1ns / 1ps

module actuated_signal_phase_controller #(
    parameter int NUM_PHASES    = 16,
    parameter int NUM_DETECTORS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  apc_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output apc_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    apc_pkg::cmd_t    cmd;
    apc_pkg::status_t status;

    assign s_ready   = cmd.take;
    assign cfg_ready = 1'b1;

    // sequencer
    apc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd)
    );

    // storage and arithmetic
    apc_datapath #(
        .NUM_PHASES    (NUM_PHASES),
        .NUM_DETECTORS (NUM_DETECTORS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: rtl/core/apc_checker.sv
// port-level checks for the signal phase controller, bound to the top level
`timescale 1ns / 1ps

module apc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input apc_pkg::in_item_t                s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input apc_pkg::out_item_t               m_data
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an evaluate transaction closes the input until its result is formed
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == apc_pkg::KIND_EVAL |=> !s_ready)
        else $error("input still open after evaluate");

    // an extension is never zero
    a_ext_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.switched |-> m_data.next_delay_ms != 24'd0)
        else $error("zero extension");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind actuated_signal_phase_controller apc_checker u_apc_checker (.*);

// File: dv/tb_actuated_signal_phase_controller.sv
// self-checking testbench for the actuated signal phase controller
`timescale 1ns / 1ps

module tb_actuated_signal_phase_controller;

    localparam int  N_PHASES    = 16;
    localparam int  N_DETECTORS = 16;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  IDLE_PCT    = 31;
    localparam int  SETTLE      = 60;
    localparam int  IN_W        = $bits(apc_pkg::in_item_t);
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    apc_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    apc_pkg::out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [apc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [apc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    actuated_signal_phase_controller #(
        .NUM_PHASES(N_PHASES),
        .NUM_DETECTORS(N_DETECTORS)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // shadow copy of the controller state
    logic [23:0] tbl_min [N_PHASES];
    logic [23:0] tbl_max [N_PHASES];
    logic        tbl_green [N_PHASES];
    logic [15:0] tbl_mask [N_PHASES];
    logic [15:0] det_gap [N_DETECTORS];
    logic [3:0]  cur_phase;
    logic [31:0] phase_start;
    logic [4:0]  cfg_count;
    logic [15:0] cfg_max_gap;
    logic [15:0] cfg_det_gap;
    logic        cfg_gap_en;

    apc_pkg::out_item_t expected_results[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_switch = 0;
    int n_extend = 0;
    int cycles = 0;
    bit no_idle = 0;

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_actuated_signal_phase_controller: done, errors");
            $finish;
        end
    end

    // result checker and ready throttle
    always @(posedge aclk) begin
        apc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("unexpected result %p", m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.next_delay_ms !== want.next_delay_ms) begin
                    $error("next_delay_ms expected %0d actual %0d",
                           want.next_delay_ms, m_data.next_delay_ms);
                    errors++;
                end
                if (m_data.active_phase !== want.active_phase) begin
                    $error("active_phase expected %0d actual %0d",
                           want.active_phase, m_data.active_phase);
                    errors++;
                end
                if (m_data.switched !== want.switched) begin
                    $error("switched expected %0d actual %0d",
                           want.switched, m_data.switched);
                    errors++;
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // predict the effect of one accepted transaction
    task automatic apply_signal_step(input apc_pkg::in_item_t x);
        logic [31:0] elapsed;
        logic [23:0] mx;
        logic [15:0] best;
        logic [4:0]  cnt;
        logic [3:0]  nxt;
        bit found;
        longint d, g, cap, tot;
        apc_pkg::out_item_t r;
        found = 1'b0;
        best = 16'hFFFF;
        case (x.kind)
            apc_pkg::KIND_GAP: det_gap[x.detector_index] = x.gap_ms;
            apc_pkg::KIND_LOAD: begin
                tbl_min[x.phase_slot] = x.min_time_ms;
                tbl_max[x.phase_slot] = x.max_time_ms;
                tbl_green[x.phase_slot] = x.green_flag;
                tbl_mask[x.phase_slot] = x.green_detectors;
            end
            apc_pkg::KIND_EVAL: begin
                elapsed = x.now_ms - phase_start;
                mx = tbl_max[cur_phase];
                if (tbl_green[cur_phase] && elapsed < {8'd0, mx} && cfg_gap_en) begin
                    for (int i = 0; i < N_DETECTORS; i++) begin
                        if (tbl_mask[cur_phase][i] && det_gap[i] < cfg_max_gap) begin
                            if (!found || det_gap[i] < best) best = det_gap[i];
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    d = longint'(tbl_min[cur_phase]) - longint'(elapsed);
                    g = longint'(cfg_det_gap) - longint'(best);
                    cap = longint'(mx) - longint'(elapsed);
                    if (g > d) d = g;
                    if (d < 1) d = 1;
                    if (d % 1000 != 0) begin
                        tot = d + longint'(elapsed);
                        d = (tot / 1000 + 1) * 1000 - longint'(elapsed);
                    end
                    if (d > cap) d = cap;
                    r.next_delay_ms = d[23:0];
                    r.active_phase = cur_phase;
                    r.switched = 1'b0;
                    n_extend++;
                end else begin
                    cnt = cfg_count;
                    if (cnt < 5'd1) cnt = 5'd1;
                    if (cnt > 5'd16) cnt = 5'd16;
                    nxt = ({1'b0, cur_phase} + 5'd1 >= cnt) ? 4'd0 : cur_phase + 4'd1;
                    cur_phase = nxt;
                    phase_start = x.now_ms;
                    r.next_delay_ms = tbl_min[nxt];
                    r.active_phase = nxt;
                    r.switched = 1'b1;
                    n_switch++;
                end
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // send one transaction on the input channel
    task automatic send_item(input apc_pkg::in_item_t x);
        int gap;
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        apply_signal_step(x);
        n_items++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [apc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            apc_pkg::CFG_PHASE_COUNT: cfg_count = val[4:0];
            apc_pkg::CFG_MAX_GAP:     cfg_max_gap = val;
            apc_pkg::CFG_DET_GAP:     cfg_det_gap = val;
            apc_pkg::CFG_GAP_ENABLE:  cfg_gap_en = val[0];
            default: ;
        endcase
    endtask

    // random fill for the fields a transaction does not use
    function automatic apc_pkg::in_item_t rand_item;
        return apc_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    endfunction

    function automatic apc_pkg::in_item_t mk_gap(input logic [3:0] det,
                                                 input logic [15:0] g);
        apc_pkg::in_item_t x;
        x = rand_item();
        x.kind = apc_pkg::KIND_GAP;
        x.detector_index = det;
        x.gap_ms = g;
        return x;
    endfunction

    function automatic apc_pkg::in_item_t mk_load(input logic [3:0] slot,
                                                  input logic [23:0] mn,
                                                  input logic [23:0] mx, input logic gr,
                                                  input logic [15:0] mask);
        apc_pkg::in_item_t x;
        x = rand_item();
        x.kind = apc_pkg::KIND_LOAD;
        x.phase_slot = slot;
        x.min_time_ms = mn;
        x.max_time_ms = mx;
        x.green_flag = gr;
        x.green_detectors = mask;
        return x;
    endfunction

    function automatic apc_pkg::in_item_t mk_eval(input logic [31:0] now);
        apc_pkg::in_item_t x;
        x = rand_item();
        x.kind = apc_pkg::KIND_EVAL;
        x.now_ms = now;
        return x;
    endfunction

    function automatic apc_pkg::in_item_t mk_unused;
        apc_pkg::in_item_t x;
        x = rand_item();
        x.kind = KIND_UNUSED;
        return x;
    endfunction

    // evaluation time near the current phase, sometimes anywhere
    function automatic logic [31:0] pick_now;
        if ($urandom_range(99) < 85)
            return phase_start + $urandom_range(0, int'(tbl_max[cur_phase]) + 3000);
        return $urandom;
    endfunction

    // whole phase table first, so every phase read is of a loaded entry
    task automatic test_load_table;
        send_item(mk_load(4'd0, 24'd0, 24'hFFFFFF, 1'b1, 16'hFFFF));
        send_item(mk_load(4'd15, 24'hFFFFFF, 24'd0, 1'b0, 16'h0000));
        for (int s = 1; s < 15; s++)
            send_item(mk_load(s[3:0], 24'($urandom_range(500, 6000)),
                              24'($urandom_range(2000, 30000)),
                              1'($urandom_range(1)), 16'($urandom)));
    endtask

    // gap extremes, unused kind, extend and switch, time wrap
    task automatic test_directed;
        send_item(mk_gap(4'd0, 16'd0));
        send_item(mk_gap(4'd15, 16'hFFFF));
        send_item(mk_gap(4'd3, 16'd3099));
        send_item(mk_unused());
        send_item(mk_eval(32'd1));
        send_item(mk_eval(32'd1000));
        send_item(mk_eval(32'hFFFF_FFF0));
        send_item(mk_eval(32'h0000_0100));
        drain();
    endtask

    task automatic random_item;
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            send_item(mk_gap(4'($urandom),
                             16'(($urandom_range(9) < 7) ? $urandom_range(0, 5000)
                                                         : $urandom)));
        else if (sel < 40)
            send_item(mk_load(4'($urandom),
                              24'(($urandom_range(9) < 8) ? $urandom_range(0, 8000)
                                                          : $urandom),
                              24'(($urandom_range(9) < 8) ? $urandom_range(0, 30000)
                                                          : $urandom),
                              $urandom_range(99) < 75, 16'($urandom)));
        else if (sel < 95)
            send_item(mk_eval(pick_now()));
        else begin
            send_item(mk_eval(pick_now()));
            send_item(mk_unused());
        end
    endtask

    // several register settings, extremes among them
    task automatic test_config_sweep;
        logic [15:0] counts [6] = '{16'd0, 16'd1, 16'd16, 16'd17, 16'd31, 16'd3};
        for (int k = 0; k < 6; k++) begin
            write_reg(apc_pkg::CFG_PHASE_COUNT, counts[k]);
            write_reg(apc_pkg::CFG_MAX_GAP, (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF
                                            : 16'($urandom_range(500, 6000)));
            write_reg(apc_pkg::CFG_DET_GAP, (k == 2) ? 16'd0 : (k == 3) ? 16'hFFFF
                                            : 16'($urandom_range(0, 6000)));
            write_reg(apc_pkg::CFG_GAP_ENABLE, (k == 4) ? 16'd0 : 16'd1);
            repeat (30) random_item();
            drain();
        end
    endtask

    task automatic test_random;
        write_reg(apc_pkg::CFG_PHASE_COUNT, 16'd16);
        write_reg(apc_pkg::CFG_MAX_GAP, 16'd3100);
        write_reg(apc_pkg::CFG_DET_GAP, 16'd3000);
        write_reg(apc_pkg::CFG_GAP_ENABLE, 16'd1);
        for (int i = 0; i < 900; i++) begin
            no_idle = (i >= 400 && i < 550);
            random_item();
        end
        no_idle = 0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < N_DETECTORS; i++) det_gap[i] = 16'hFFFF;
        for (int i = 0; i < N_PHASES; i++) begin
            tbl_min[i] = '0;
            tbl_max[i] = '0;
            tbl_green[i] = 1'b0;
            tbl_mask[i] = '0;
        end
        cur_phase = '0;
        phase_start = '0;
        cfg_count = apc_pkg::RST_PHASE_COUNT;
        cfg_max_gap = apc_pkg::RST_MAX_GAP;
        cfg_det_gap = apc_pkg::RST_DET_GAP;
        cfg_gap_en = apc_pkg::RST_GAP_ENABLE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_table();
        test_directed();
        test_config_sweep();
        test_random();
        $display("covered %0d transactions, %0d results (%0d phase switches, %0d extensions)",
                 n_items, n_results, n_switch, n_extend);
        $display("register sweep included phase counts 0, 1, 16, 17, 31 and gap detection off");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_actuated_signal_phase_controller: done, clean");
        end else begin
            $display("tb_actuated_signal_phase_controller: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/apc_pkg.sv
rtl/core/apc_ram.sv
rtl/core/apc_datapath.sv
rtl/core/apc_ctrl.sv
rtl/core/actuated_signal_phase_controller.sv
rtl/core/apc_checker.sv
dv/tb_actuated_signal_phase_controller.sv
